>>> hw/rtl/ssar_pkg.sv
// Package for the sample statistics reporter: types, constants, microcode ROM, digit helpers.
package ssar_pkg;

    // Statistic widths
    localparam int COUNT_BITS = 16;
    localparam int SAMPLE_BITS = 8;
    localparam int TOTAL_BITS = 24;
    // Only positive totals are divided, so the dividend has one bit less than the total
    localparam int DIV_BITS = TOTAL_BITS - 1;
    localparam int DIV_STEPS = DIV_BITS;
    localparam int ITER_BITS = $clog2(DIV_STEPS + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic signed [TOTAL_BITS-1:0] TOTAL_MAX = {1'b0, {(TOTAL_BITS-1){1'b1}}};
    localparam logic signed [TOTAL_BITS-1:0] TOTAL_MIN = {1'b1, {(TOTAL_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // ASCII codes
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [6:0] CLAMP_HI = 7'd99;
    localparam logic [3:0] RADIX = 4'd10;

    // Program store
    localparam int PROG_LEN = 16;
    localparam int PC_BITS = $clog2(PROG_LEN);
    typedef logic [PC_BITS-1:0] pc_t;

    localparam pc_t PC_START = PC_BITS'(0);
    localparam pc_t PC_DIV_INIT = PC_BITS'(1);
    localparam pc_t PC_DIV_STEP = PC_BITS'(2);

    typedef enum logic [1:0] {
        UOP_ACCEPT,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_EMIT
    } uop_t;

    typedef enum logic [1:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_ITER_LEFT
    } cond_t;

    typedef enum logic [3:0] {
        BSEL_CR,
        BSEL_LF,
        BSEL_CUR_TENS,
        BSEL_CUR_ONES,
        BSEL_AVG_TENS,
        BSEL_AVG_ONES,
        BSEL_MAX_TENS,
        BSEL_MAX_ONES,
        BSEL_MIN_TENS,
        BSEL_MIN_ONES
    } byte_sel_t;

    typedef struct packed {
        uop_t      op;
        cond_t     cond;
        pc_t       target;
        byte_sel_t bsel;
        logic      last;
    } ucode_t;

    // Control bundle from sequencer to datapath
    typedef struct packed {
        uop_t      op;
        logic      fire;
        byte_sel_t bsel;
        logic      last;
    } ctl_t;

    // Status bundle from datapath to sequencer
    typedef struct packed {
        logic iter_last;
    } status_t;

    // Microcode: accept, set up divide, bit-serial divide loop, then 13 report words
    function automatic ucode_t ucode_rom(input pc_t addr);
        ucode_t w;
        w = '{op: UOP_EMIT, cond: COND_NONE, target: PC_START, bsel: BSEL_LF, last: 1'b0};
        unique case (addr)
            PC_BITS'(0):  w = '{UOP_ACCEPT, COND_NONE, PC_START, BSEL_CR, 1'b0};
            PC_BITS'(1):  w = '{UOP_DIV_INIT, COND_NONE, PC_START, BSEL_CR, 1'b0};
            PC_BITS'(2):  w = '{UOP_DIV_STEP, COND_ITER_LEFT, PC_DIV_STEP, BSEL_CR, 1'b0};
            PC_BITS'(3):  w.bsel = BSEL_CR;
            PC_BITS'(4):  w.bsel = BSEL_CUR_TENS;
            PC_BITS'(5):  w.bsel = BSEL_CUR_ONES;
            PC_BITS'(6):  w.bsel = BSEL_LF;
            PC_BITS'(7):  w.bsel = BSEL_AVG_TENS;
            PC_BITS'(8):  w.bsel = BSEL_AVG_ONES;
            PC_BITS'(9):  w.bsel = BSEL_LF;
            PC_BITS'(10): w.bsel = BSEL_MAX_TENS;
            PC_BITS'(11): w.bsel = BSEL_MAX_ONES;
            PC_BITS'(12): w.bsel = BSEL_LF;
            PC_BITS'(13): w.bsel = BSEL_MIN_TENS;
            PC_BITS'(14): w.bsel = BSEL_MIN_ONES;
            PC_BITS'(15): w = '{UOP_EMIT, COND_ALWAYS, PC_START, BSEL_LF, 1'b1};
            default:      w = '{UOP_ACCEPT, COND_ALWAYS, PC_START, BSEL_CR, 1'b0};
        endcase
        return w;
    endfunction

    // Clamp a signed sample-width value to 0..99
    function automatic logic [6:0] clamp99_s(input logic signed [SAMPLE_BITS-1:0] v);
        logic [6:0] r;
        if (v < 0) begin
            r = 7'd0;
        end else if (v > $signed({1'b0, CLAMP_HI})) begin
            r = CLAMP_HI;
        end else begin
            r = v[6:0];
        end
        return r;
    endfunction

    // Clamp an unsigned quotient to 0..99
    function automatic logic [6:0] clamp99_u(input logic [DIV_BITS-1:0] v);
        logic [6:0] r;
        if (v > DIV_BITS'(CLAMP_HI)) begin
            r = CLAMP_HI;
        end else begin
            r = v[6:0];
        end
        return r;
    endfunction

    // Tens digit by reciprocal multiply, exact for 0..99
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v);
        logic [6:0] t;
        t = 7'(tens_of(v)) * 7'(RADIX);
        return 4'(v - t);
    endfunction

endpackage

>>> hw/rtl/ssar_sample_if.sv
// Input channel interface: one temperature sample per word.
interface ssar_sample_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [ssar_pkg::SAMPLE_BITS-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

>>> hw/rtl/ssar_report_if.sv
// Output channel interface: one ASCII report byte per word.
interface ssar_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;
    logic       last_byte;

    modport source (output valid, output report_byte, output last_byte, input ready);
    modport sink   (input valid, input report_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/sample_stats_ascii_reporter_unit.sv
// Per sample: accept, divider set-up, 23 divide steps (one quotient bit per cycle in the
//   restoring divider) and 13 report words; the next sample is accepted only after the frame.
// The next sample is taken while the last word of a frame still waits in the output register.
// Reset: rst_n clears total and count, sets max to -128 and min to 127, empties the output.
// Top level: microcoded sequencer, datapath and the output register.
module sample_stats_ascii_reporter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    ssar_sample_if.sink          samples,
    ssar_report_if.source        report
);

    ssar_pkg::ctl_t    ctl;
    ssar_pkg::status_t status;
    logic [7:0]        byte_sel;
    logic              out_valid_reg;
    logic [7:0]        out_byte_reg;
    logic              out_last_reg;
    logic              out_free;

    assign out_free = !out_valid_reg || report.ready;

    ssar_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .out_free (out_free),
        .status   (status),
        .ctl      (ctl)
    );

    ssar_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .sample   (samples.sample),
        .status   (status),
        .byte_out (byte_sel)
    );

    assign samples.ready = (ctl.op == ssar_pkg::UOP_ACCEPT);

    wire emit = ctl.fire && (ctl.op == ssar_pkg::UOP_EMIT);

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (report.ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit) begin
            out_byte_reg <= byte_sel;
            out_last_reg <= ctl.last;
        end
    end

    assign report.valid       = out_valid_reg;
    assign report.report_byte = out_byte_reg;
    assign report.last_byte   = out_last_reg;

`ifndef SYNTH
    // An accepted sample always starts the divider set-up next
    a_accept_then_div: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> (ctl.op == ssar_pkg::UOP_DIV_INIT))
        else $error("accepted sample not followed by divider set-up");

    // The frame's final word returns the sequencer to the accept step
    a_last_then_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && ctl.last) |=> (ctl.op == ssar_pkg::UOP_ACCEPT))
        else $error("sequencer did not return to accept after last word");

    // The last flag only rides on a line feed
    a_last_is_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (out_byte_reg == ssar_pkg::CHAR_LF))
        else $error("last word is not a line feed");

    // Every report word is CR, LF or a decimal digit
    a_byte_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_byte_reg == ssar_pkg::CHAR_CR) ||
                           (out_byte_reg == ssar_pkg::CHAR_LF) ||
                           ((out_byte_reg >= ssar_pkg::CHAR_ZERO) &&
                            (out_byte_reg <= ssar_pkg::CHAR_NINE))))
        else $error("report word outside the frame alphabet");
`endif

endmodule

>>> hw/rtl/ssar_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module ssar_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                out_free,
    input  ssar_pkg::status_t   status,
    output ssar_pkg::ctl_t      ctl
);

    ssar_pkg::pc_t    pc_reg;
    ssar_pkg::pc_t    pc_next;
    ssar_pkg::ucode_t uword;
    logic             fire;

    assign uword = ssar_pkg::ucode_rom(pc_reg);

    // Step completes when its handshake side is ready
    always_comb
    begin
        unique case (uword.op)
            ssar_pkg::UOP_ACCEPT: fire = in_valid;
            ssar_pkg::UOP_EMIT:   fire = out_free;
            default:              fire = 1'b1;
        endcase
    end

    // Next step
    always_comb
    begin
        if (!fire) begin
            pc_next = pc_reg;
        end else begin
            unique case (uword.cond)
                ssar_pkg::COND_ALWAYS:    pc_next = uword.target;
                ssar_pkg::COND_ITER_LEFT: pc_next = status.iter_last ?
                                                    ssar_pkg::PC_BITS'(pc_reg + 1'b1) :
                                                    uword.target;
                default:                  pc_next = ssar_pkg::PC_BITS'(pc_reg + 1'b1);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pc_reg <= ssar_pkg::PC_START;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign ctl.op   = uword.op;
    assign ctl.fire = fire;
    assign ctl.bsel = uword.bsel;
    assign ctl.last = uword.last;

endmodule

>>> hw/rtl/ssar_dp.sv
// Datapath: running statistics, bit-serial divider and report byte select.
module ssar_dp (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  ssar_pkg::ctl_t                          ctl,
    input  logic signed [ssar_pkg::SAMPLE_BITS-1:0] sample,
    output ssar_pkg::status_t                       status,
    output logic [7:0]                              byte_out
);

    localparam int CB = ssar_pkg::COUNT_BITS;
    localparam int DB = ssar_pkg::DIV_BITS;
    localparam int TB = ssar_pkg::TOTAL_BITS;

    logic signed [ssar_pkg::SAMPLE_BITS-1:0] sample_reg;
    logic signed [ssar_pkg::SAMPLE_BITS-1:0] max_reg;
    logic signed [ssar_pkg::SAMPLE_BITS-1:0] min_reg;
    logic signed [TB-1:0]                    total_reg;
    logic signed [TB-1:0]                    total_next;
    logic [CB-1:0]                           count_reg;
    logic [DB-1:0]                           quo_reg;
    logic [CB-1:0]                           rem_reg;
    logic [ssar_pkg::ITER_BITS-1:0]          iter_reg;

    logic signed [TB:0] sum;
    logic [CB:0]        shifted;
    logic [CB:0]        trial;
    logic               take;

    logic [6:0] cur_v;
    logic [6:0] avg_v;
    logic [6:0] max_v;
    logic [6:0] min_v;

    wire accept = ctl.fire && (ctl.op == ssar_pkg::UOP_ACCEPT);

    // Saturating add of the sample into the total
    always_comb
    begin
        sum = $signed({total_reg[TB-1], total_reg}) + (TB+1)'(sample);
        if (sum[TB] != sum[TB-1]) begin
            total_next = sum[TB] ? ssar_pkg::TOTAL_MIN : ssar_pkg::TOTAL_MAX;
        end else begin
            total_next = sum[TB-1:0];
        end
    end

    // Statistics state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            total_reg <= '0;
            count_reg <= '0;
            max_reg   <= ssar_pkg::SAMPLE_MIN;
            min_reg   <= ssar_pkg::SAMPLE_MAX;
        end else if (accept) begin
            if (count_reg != ssar_pkg::COUNT_MAX) begin
                total_reg <= total_next;
                count_reg <= count_reg + 1'b1;
            end
            if (sample > max_reg) begin
                max_reg <= sample;
            end
            if (sample < min_reg) begin
                min_reg <= sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            sample_reg <= sample;
        end
    end

    // Restoring divide step, one quotient bit per cycle
    assign shifted = {rem_reg, quo_reg[DB-1]};
    assign trial   = shifted - {1'b0, count_reg};
    assign take    = (shifted >= {1'b0, count_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            iter_reg <= '0;
        end else if (ctl.fire && (ctl.op == ssar_pkg::UOP_DIV_INIT)) begin
            iter_reg <= ssar_pkg::ITER_BITS'(ssar_pkg::DIV_STEPS);
        end else if (ctl.fire && (ctl.op == ssar_pkg::UOP_DIV_STEP)) begin
            iter_reg <= iter_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fire && (ctl.op == ssar_pkg::UOP_DIV_INIT)) begin
            // A total at or below zero averages to zero or less, which clamps to zero
            quo_reg <= (total_reg > 0) ? total_reg[DB-1:0] : '0;
            rem_reg <= '0;
        end else if (ctl.fire && (ctl.op == ssar_pkg::UOP_DIV_STEP)) begin
            quo_reg <= {quo_reg[DB-2:0], take};
            rem_reg <= take ? trial[CB-1:0] : shifted[CB-1:0];
        end
    end

    assign status.iter_last = (iter_reg == ssar_pkg::ITER_BITS'(1));

    // Report byte select
    assign cur_v = ssar_pkg::clamp99_s(sample_reg);
    assign avg_v = ssar_pkg::clamp99_u(quo_reg);
    assign max_v = ssar_pkg::clamp99_s(max_reg);
    assign min_v = ssar_pkg::clamp99_s(min_reg);

    always_comb
    begin
        unique case (ctl.bsel)
            ssar_pkg::BSEL_CR:       byte_out = ssar_pkg::CHAR_CR;
            ssar_pkg::BSEL_LF:       byte_out = ssar_pkg::CHAR_LF;
            ssar_pkg::BSEL_CUR_TENS: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::tens_of(cur_v));
            ssar_pkg::BSEL_CUR_ONES: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::ones_of(cur_v));
            ssar_pkg::BSEL_AVG_TENS: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::tens_of(avg_v));
            ssar_pkg::BSEL_AVG_ONES: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::ones_of(avg_v));
            ssar_pkg::BSEL_MAX_TENS: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::tens_of(max_v));
            ssar_pkg::BSEL_MAX_ONES: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::ones_of(max_v));
            ssar_pkg::BSEL_MIN_TENS: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::tens_of(min_v));
            ssar_pkg::BSEL_MIN_ONES: byte_out = ssar_pkg::CHAR_ZERO + 8'(ssar_pkg::ones_of(min_v));
            default:                 byte_out = ssar_pkg::CHAR_LF;
        endcase
    end

endmodule
